/* rtl/core/mdu_pkg.sv */
// Modular division unit: shared package.
// Holds the datapath command codes, the status struct and fixed constants.
// No dependencies.
package mdu_pkg;

  // Modulus value after reset (truncated to the value width on use)
  localparam logic [63:0] MODULUS_RESET = 64'd998244353;

  // Commands from the controller to the datapath
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_LOAD     = 3'd1,  // take a new beat, set up dividend reduction
    CMD_ALIGN    = 3'd2,  // shift divisor copy up one place
    CMD_DIV      = 3'd3,  // one restoring step, shift divisor copy down
    CMD_LOAD_B   = 3'd4,  // keep reduced dividend, set up first Euclid step
    CMD_SWAP     = 3'd5,  // rotate remainders and coefficients
    CMD_PREP_MUL = 3'd6,  // normalize inverse, set up multiply
    CMD_MUL      = 3'd7   // one shift-add modular multiply step
  } cmd_e;

  // Status from the datapath to the controller
  typedef struct packed {
    logic m_zero;     // modulus register is zero
    logic ds_le_rp;   // shifted divisor still fits in the remainder
    logic k_zero;     // step counter is zero
    logic k_one;      // step counter is one
    logic rp_zero;    // current remainder is zero
    logic rc_one;     // current divisor (gcd candidate) is one
  } status_t;

endpackage

/* rtl/core/mdu_ctrl.sv */
// Modular division unit: controller state machine.
// Sequences reduction, Euclid division steps and the final multiply.
// Depends on mdu_pkg.
module mdu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mdu_pkg::status_t  status_i,
  output mdu_pkg::cmd_e     cmd_o,
  output logic              busy_o,
  output logic              done_o,
  output logic              status_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ALIGN = 6'b000010,
    S_DIV   = 6'b000100,
    S_STEP  = 6'b001000,
    S_MUL   = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   phase_a_q, phase_a_d;  // first division reduces the dividend
  logic   err_q, err_d;

  // Next state and command decode
  always_comb begin
    state_d   = state_q;
    phase_a_d = phase_a_q;
    err_d     = err_q;
    cmd_o     = mdu_pkg::CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o     = mdu_pkg::CMD_LOAD;
          phase_a_d = 1'b1;
          err_d     = status_i.m_zero;
          state_d   = status_i.m_zero ? S_RESP : S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (status_i.ds_le_rp) begin
          cmd_o = mdu_pkg::CMD_ALIGN;
        end else if (status_i.k_zero) begin
          state_d = S_STEP;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o = mdu_pkg::CMD_DIV;
        if (status_i.k_one) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (phase_a_q) begin
          cmd_o     = mdu_pkg::CMD_LOAD_B;
          phase_a_d = 1'b0;
          state_d   = S_ALIGN;
        end else if (status_i.rp_zero) begin
          // Euclid finished: gcd sits in the divisor register
          if (status_i.rc_one) begin
            cmd_o   = mdu_pkg::CMD_PREP_MUL;
            state_d = S_MUL;
          end else begin
            err_d   = 1'b1;
            state_d = S_RESP;
          end
        end else begin
          cmd_o   = mdu_pkg::CMD_SWAP;
          state_d = S_ALIGN;
        end
      end
      S_MUL: begin
        cmd_o = mdu_pkg::CMD_MUL;
        if (status_i.k_one) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_a_q <= 1'b0;
      err_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_a_q <= phase_a_d;
      err_q     <= err_d;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = (state_q == S_RESP);
  assign status_o = err_q;

endmodule

/* rtl/core/mdu_datapath.sv */
// Modular division unit: datapath.
// Modulus register, shift-subtract divider with coefficient tracking,
// inverse normalization and shift-add modular multiplier. Depends on mdu_pkg.
module mdu_datapath #(
  parameter int VALUE_BITS = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [VALUE_BITS-1:0] cfg_wdata_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  input  mdu_pkg::cmd_e         cmd_i,
  output mdu_pkg::status_t      status_o,
  output logic [VALUE_BITS-1:0] quotient_o
);

  localparam int W   = VALUE_BITS;
  localparam int CPW = W + 2;            // Euclid coefficients, |c| <= m
  localparam int CSW = W + 4;            // shifted coefficient, |c << k| <= 4m
  localparam int KW  = $clog2(W + 2);    // shift / step counter

  logic [W-1:0]            mod_q;
  logic [W-1:0]            rp_q, rc_q;   // remainder / divisor (rc is multiplier later)
  logic [W-1:0]            b_q, a_q, acc_q;
  logic signed [CPW-1:0]   cp_q, cc_q;
  logic [W:0]              ds_q;         // divisor shifted into place
  logic signed [CSW-1:0]   cs_q;         // divisor's coefficient shifted alike
  logic [KW-1:0]           k_q;

  logic [W:0]              ds_half;
  logic signed [CSW-1:0]   cs_half;
  logic                    div_fit;
  logic [W-1:0]            rp_sub;
  logic signed [CSW-1:0]   cp_wide, cp_sub_w;
  logic signed [CPW-1:0]   mod_ext, inv_neg, inv_sub;
  logic [W-1:0]            inv;
  logic [W:0]              acc_sum, acc_red, a_dbl, a_red;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= mdu_pkg::MODULUS_RESET[W-1:0];
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  // Restoring division step: shift divisor copy down, subtract if it fits
  assign ds_half  = ds_q >> 1;
  assign cs_half  = cs_q >>> 1;
  assign div_fit  = ({1'b0, rp_q} >= ds_half);
  assign rp_sub   = rp_q - ds_half[W-1:0];
  assign cp_wide  = CSW'(cp_q);
  assign cp_sub_w = cp_wide - cs_half;

  // Inverse normalized into 0..m-1
  assign mod_ext = $signed({2'b00, mod_q});
  assign inv_neg = mod_ext + cc_q;
  assign inv_sub = cc_q - mod_ext;
  always_comb begin
    if (cc_q < 0) begin
      inv = inv_neg[W-1:0];
    end else if (cc_q >= mod_ext) begin
      inv = inv_sub[W-1:0];
    end else begin
      inv = cc_q[W-1:0];
    end
  end

  // Modular multiply step: conditional add and doubling, each reduced once
  assign acc_sum = {1'b0, acc_q} + {1'b0, a_q};
  assign acc_red = (acc_sum >= {1'b0, mod_q}) ? acc_sum - {1'b0, mod_q} : acc_sum;
  assign a_dbl   = {a_q, 1'b0};
  assign a_red   = (a_dbl >= {1'b0, mod_q}) ? a_dbl - {1'b0, mod_q} : a_dbl;

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      mdu_pkg::CMD_NONE: begin
      end
      mdu_pkg::CMD_LOAD: begin
        rp_q  <= dividend_i;
        b_q   <= divisor_i;
        rc_q  <= mod_q;
        cp_q  <= '0;
        cc_q  <= '0;
        ds_q  <= {1'b0, mod_q};
        cs_q  <= '0;
        k_q   <= '0;
        acc_q <= '0;
      end
      mdu_pkg::CMD_ALIGN: begin
        ds_q <= {ds_q[W-1:0], 1'b0};
        cs_q <= {cs_q[CSW-2:0], 1'b0};
        k_q  <= k_q + KW'(1);
      end
      mdu_pkg::CMD_DIV: begin
        ds_q <= ds_half;
        cs_q <= cs_half;
        k_q  <= k_q - KW'(1);
        if (div_fit) begin
          rp_q <= rp_sub;
          cp_q <= cp_sub_w[CPW-1:0];
        end
      end
      mdu_pkg::CMD_LOAD_B: begin
        a_q  <= rp_q;
        rp_q <= b_q;
        rc_q <= mod_q;
        cp_q <= CPW'(1);
        cc_q <= '0;
        ds_q <= {1'b0, mod_q};
        cs_q <= '0;
        k_q  <= '0;
      end
      mdu_pkg::CMD_SWAP: begin
        rp_q <= rc_q;
        rc_q <= rp_q;
        cp_q <= cc_q;
        cc_q <= cp_q;
        ds_q <= {1'b0, rp_q};
        cs_q <= cp_wide;
        k_q  <= '0;
      end
      mdu_pkg::CMD_PREP_MUL: begin
        rc_q  <= inv;
        acc_q <= '0;
        k_q   <= KW'(W);
      end
      mdu_pkg::CMD_MUL: begin
        if (rc_q[0]) begin
          acc_q <= acc_red[W-1:0];
        end
        a_q  <= a_red[W-1:0];
        rc_q <= rc_q >> 1;
        k_q  <= k_q - KW'(1);
      end
      default: begin
      end
    endcase
  end

  // Status to the controller
  assign status_o.m_zero   = (mod_q == '0);
  assign status_o.ds_le_rp = (ds_q <= {1'b0, rp_q});
  assign status_o.k_zero   = (k_q == '0);
  assign status_o.k_one    = (k_q == KW'(1));
  assign status_o.rp_zero  = (rp_q == '0);
  assign status_o.rc_one   = (rc_q == W'(1));

  assign quotient_o = acc_q;

endmodule

/* rtl/core/modular_division_unit.sv */
// Modular division unit: top level.
// Joins the controller (mdu_ctrl) and the datapath (mdu_datapath).
// Depends on mdu_pkg.
//
//  channel   signals                          direction  handshake
//  command   start_i, dividend_i, divisor_i   in         start_i && !busy_o
//  result    done_o, quotient_o, status_o     out        done_o, one cycle
//  config    cfg_we_i, cfg_wdata_i            in         cfg_we_i, any cycle
//
// A beat runs a load cycle, one shift-subtract division per reduction and Euclid
// step, then, if an inverse exists, the multiply, and a result cycle.
// A zero modulus answers in the cycle after the beat is taken.
// Reset loads the modulus with its default and returns the controller to idle.
// The receiver cannot stall; busy_o stays high until the result cycle is over.
module modular_division_unit #(
  parameter int VALUE_BITS = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [VALUE_BITS-1:0] cfg_wdata_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic                  status_o
);

  mdu_pkg::cmd_e    cmd;
  mdu_pkg::status_t dp_status;

  mdu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .status_o (status_o)
  );

  mdu_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .dividend_i  (dividend_i),
    .divisor_i   (divisor_i),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .quotient_o  (quotient_o)
  );

endmodule

/* rtl/core/mdu_checker.sv */
// Modular division unit: port-level checker and its bind.
// Watches the top level's ports only; no package dependency.
module mdu_checker #(
  parameter int VALUE_BITS = 30
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [VALUE_BITS-1:0] cfg_wdata_i,
  input logic                  start_i,
  input logic                  busy_o,
  input logic [VALUE_BITS-1:0] dividend_i,
  input logic [VALUE_BITS-1:0] divisor_i,
  input logic                  done_o,
  input logic [VALUE_BITS-1:0] quotient_o,
  input logic                  status_o
);

  // Accepted beat makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted beat did not raise busy");

  // Result strobe lasts one cycle and ends the busy period
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe not a single cycle ending busy");

  // Result only inside a busy period
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside busy");

  // Busy only drops right after a result
  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(done_o))
    else $error("busy dropped without a result");

  // No-inverse results carry a zero quotient
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> quotient_o == '0)
    else $error("error result with nonzero quotient");

endmodule

bind modular_division_unit mdu_checker #(.VALUE_BITS(VALUE_BITS)) u_mdu_checker (.*);

/* dv/mdu_checker.sv */
`timescale 1ns / 1ps
// Checker for the modular division unit: watches modulus writes, command beats
// and result beats, predicts every result beat and compares it field by field.
// Depends on mdu_pkg for the modulus reset value.
module mdu_scoreboard #(
  parameter int VALUE_BITS = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [VALUE_BITS-1:0] cfg_wdata_i,
  input  logic                  start_i,
  input  logic                  busy_o,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  input  logic                  done_o,
  input  logic [VALUE_BITS-1:0] quotient_o,
  input  logic                  status_o,
  output int                    mismatch_o,
  output int                    pending_o
);

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_NO_INVERSE = 1'b1;
  localparam int   REPORT_LIMIT      = 10;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    value_t quotient;
    logic   status;
  } div_result_t;

  value_t      modulus_q;
  div_result_t quotient_fifo[$];

  // dividend / divisor mod m, through the inverse of the divisor (extended Euclid)
  function automatic div_result_t divide_mod(value_t m, value_t dividend, value_t divisor);
    div_result_t     res;
    longint unsigned mod_l, dividend_red, rem_prev, rem_cur, step_quo, rem_next;
    longint          coef_prev, coef_cur, coef_next;
    res.quotient = '0;
    res.status   = STATUS_NO_INVERSE;
    if (m == '0) return res;
    mod_l        = m;
    dividend_red = dividend % mod_l;
    rem_prev     = divisor % mod_l;
    rem_cur      = mod_l;
    coef_prev    = 1;
    coef_cur     = 0;
    // only the divisor's coefficient is tracked
    while (rem_cur != 0) begin
      step_quo  = rem_prev / rem_cur;
      rem_next  = rem_prev - step_quo * rem_cur;
      coef_next = coef_prev - longint'(step_quo) * coef_cur;
      rem_prev  = rem_cur;
      rem_cur   = rem_next;
      coef_prev = coef_cur;
      coef_cur  = coef_next;
    end
    // gcd not one: no inverse
    if (rem_prev != 1) return res;
    if (coef_prev < 0) coef_prev += longint'(mod_l);
    if (coef_prev >= longint'(mod_l)) coef_prev -= longint'(mod_l);
    // both factors below 2^30, product fits in 64 bits
    res.quotient = value_t'((dividend_red * $unsigned(coef_prev)) % mod_l);
    res.status   = STATUS_OK;
    return res;
  endfunction

  // modulus copy
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= value_t'(mdu_pkg::MODULUS_RESET);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // compare result beats, queue predictions for command beats
  always @(posedge clk_i) begin
    div_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (quotient_fifo.size() == 0) begin
          if (mismatch_o < REPORT_LIMIT)
            $display("[%0t] unexpected result beat: quotient %0d status %0d",
                     $time, quotient_o, status_o);
          mismatch_o++;
        end else begin
          want = quotient_fifo.pop_front();
          if (quotient_o !== want.quotient || status_o !== want.status) begin
            if (mismatch_o < REPORT_LIMIT)
              $display("[%0t] result mismatch: expected quotient %0d status %0d, ",
                       $time, want.quotient, want.status,
                       "got quotient %0d status %0d", quotient_o, status_o);
            mismatch_o++;
          end
        end
      end
      if (start_i && !busy_o)
        quotient_fifo = {quotient_fifo, divide_mod(modulus_q, dividend_i, divisor_i)};
    end
    pending_o = quotient_fifo.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the modular division unit: clock, reset, modulus writes,
// directed and random command beats with random idling, watchdog and verdict.
// Depends on mdu_pkg, modular_division_unit and mdu_scoreboard.
module tb;

  localparam int VALUE_BITS  = 30;
  localparam int CLK_HALF    = 5;
  localparam int RESET_CYCLES = 5;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASES      = 14;
  localparam int PHASE_BEATS = 100;

  typedef logic [VALUE_BITS-1:0] value_t;

  localparam value_t ALL_ONES    = '1;
  localparam value_t DEFAULT_MOD = value_t'(mdu_pkg::MODULUS_RESET);

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   cfg_we_i;
  value_t cfg_wdata_i;
  logic   start_i;
  logic   busy_o;
  value_t dividend_i;
  value_t divisor_i;
  logic   done_o;
  value_t quotient_o;
  logic   status_o;

  int     mismatches;
  int     pending;
  int     stall_cycles;
  value_t mod_cur;

  modular_division_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .done_o     (done_o),
    .quotient_o (quotient_o),
    .status_o   (status_o)
  );

  mdu_scoreboard #(
    .VALUE_BITS(VALUE_BITS)
  ) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .done_o     (done_o),
    .quotient_o (quotient_o),
    .status_o   (status_o),
    .mismatch_o (mismatches),
    .pending_o  (pending)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // watchdog: cycles with no command or result beat
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("modular_division_unit verification failed");
          $finish;
        end
      end
    end
  end

  // present one command beat, return on the edge that takes it
  task automatic send_beat(input value_t dividend, input value_t divisor);
    start_i    <= 1'b1;
    dividend_i <= dividend;
    divisor_i  <= divisor;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  // hold off until every result beat is in and the unit is idle
  task automatic settle();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy_o);
    @(posedge clk_i);
  endtask

  task automatic write_modulus(input value_t value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    mod_cur      = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 20);
    return $urandom_range(50, 300);
  endfunction

  // idle between beats; sometimes only once the unit has gone idle
  task automatic idle_between(input bit back_to_back);
    int unsigned gap;
    gap = rand_gap();
    if (back_to_back || gap == 0) return;
    start_i <= 1'b0;
    if ($urandom_range(0, 3) == 0) begin
      do @(negedge clk_i); while (busy_o);
      @(posedge clk_i);
    end
    repeat (gap) @(posedge clk_i);
  endtask

  function automatic value_t pick_modulus();
    case ($urandom_range(0, 9))
      0:       return value_t'(2);
      1:       return ALL_ONES;
      2:       return DEFAULT_MOD;
      3:       return value_t'($urandom_range(0, 1));
      4, 5:    return value_t'($urandom_range(3, 100));
      default: return value_t'($urandom_range(2, ALL_ONES));
    endcase
  endfunction

  // operands below, at and above the modulus, plus the field extremes
  function automatic value_t pick_operand(input value_t m);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return m;
      3:       return m - 1'b1;
      4, 5, 6, 7, 8, 9: begin
        if (m == '0) return value_t'($urandom);
        return value_t'($urandom_range(0, m - 1'b1));
      end
      default: return value_t'($urandom);
    endcase
  endfunction

  initial begin
    bit back_to_back;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    start_i     <= 1'b0;
    dividend_i  <= '0;
    divisor_i   <= '0;
    stall_cycles = 0;
    mod_cur      = DEFAULT_MOD;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset modulus: zero divisor, divisor equal to modulus, operands above it
    send_beat('0, value_t'(1));
    send_beat(ALL_ONES, ALL_ONES);
    send_beat(value_t'(1), '0);
    send_beat(value_t'(5), DEFAULT_MOD);
    send_beat(ALL_ONES, DEFAULT_MOD + 1'b1);
    send_beat(value_t'(12345), value_t'(2));

    // smallest modulus above one
    settle();
    write_modulus(value_t'(2));
    send_beat(value_t'(1), value_t'(1));
    send_beat(ALL_ONES, ALL_ONES);
    send_beat(value_t'(3), value_t'(2));

    // zero modulus: nothing can be reduced
    settle();
    write_modulus('0);
    send_beat(value_t'(7), value_t'(3));

    // modulus one: everything reduces to zero
    settle();
    write_modulus(value_t'(1));
    send_beat(ALL_ONES, ALL_ONES);
    send_beat('0, '0);

    // largest modulus, composite
    settle();
    write_modulus(ALL_ONES);
    send_beat(ALL_ONES, value_t'(3));
    send_beat(value_t'(1), ALL_ONES);
    send_beat(ALL_ONES - 1'b1, ALL_ONES - 1'b1);
    send_beat(value_t'(5), '0);

    // small composite modulus: one invertible, one not
    settle();
    write_modulus(value_t'(12));
    send_beat(value_t'(7), value_t'(5));
    send_beat(value_t'(7), value_t'(6));

    // random phases, each under its own modulus
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_modulus(pick_modulus());
      back_to_back = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_beat(pick_operand(mod_cur), pick_operand(mod_cur));
        idle_between(back_to_back);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("modular_division_unit verification clean");
    end else begin
      $display("modular_division_unit verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mdu_pkg.sv
rtl/core/mdu_ctrl.sv
rtl/core/mdu_datapath.sv
rtl/core/modular_division_unit.sv
rtl/core/mdu_checker.sv
dv/mdu_checker.sv
dv/tb.sv
